### src/mwf_pkg.sv
// ----------------------------------------------------------------------------
// Modulated delay package
// Shared types and constants for the wow and flutter modulated delay line.
// ----------------------------------------------------------------------------
`default_nettype none

package mwf_pkg;

  localparam int BUFFER_DEPTH_DEF    = 2048;
  localparam int CHANNELS_DEF        = 2;
  localparam int SINE_TABLE_SIZE_DEF = 1024;
  localparam int SAMPLE_BITS_DEF     = 24;

  localparam int NOISE_BITS  = 24;
  localparam int ADDR_BITS   = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] MAX_Q23_U   = 64'd8388607;

  localparam logic signed [26:0] MAX_Q23 = 27'sd8388607;
  localparam logic signed [26:0] MIN_Q23 = -27'sd8388608;

  localparam logic [16:0] WOW_MIX  = 17'd39322;
  localparam logic [16:0] SINE_MIX = 17'd26214;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_EFFECT_ON   = 3'd0;
  localparam logic [2:0] REG_ACTIVE_CH   = 3'd1;
  localparam logic [2:0] REG_BASE_DELAY  = 3'd2;
  localparam logic [2:0] REG_DEPTH       = 3'd3;
  localparam logic [2:0] REG_WOW_COEF    = 3'd4;
  localparam logic [2:0] REG_FLUTTER_INC = 3'd5;
  localparam logic [2:0] REG_JITTER_GAIN = 3'd6;

  typedef struct packed {
    logic        effect_on;
    logic [1:0]  active_channels;
    logic [18:0] base_delay;
    logic [18:0] depth;
    logic [15:0] wow_coefficient;
    logic [31:0] flutter_increment;
    logic [15:0] jitter_gain;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### src/mwf_queue.sv
// ----------------------------------------------------------------------------
// Work queue
// Two-entry queue between the modulation front end and the delay back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mwf_queue #(
  parameter int Width = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [Width-1:0] push_data,
  input  wire logic             pop,
  output logic [Width-1:0]      pop_data,
  output mwf_pkg::q_stat_t      stat
);
  import mwf_pkg::*;

  logic [Width-1:0] slot_r [QUEUE_DEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign do_push = push && (count_r != 2'(QUEUE_DEPTH));
  assign do_pop  = pop && (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'(QUEUE_DEPTH));
  assign stat.empty = (count_r == 2'd0);

endmodule

`default_nettype wire

### src/mwf_front.sv
// ----------------------------------------------------------------------------
// Modulation front end
// Accepts frames, runs wow and flutter and turns them into a clamped delay.
// ----------------------------------------------------------------------------
`default_nettype none

module mwf_front #(
  parameter int BufferDepth   = 2048,
  parameter int Channels      = 2,
  parameter int SineTableSize = 1024,
  parameter int SampleBits    = 24,
  parameter int EntryWidth    = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mwf_pkg::cfg_t           cfg,
  input  wire logic                    clearing,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [SampleBits-1:0]   in_sample_ch0,
  input  wire logic [SampleBits-1:0]   in_sample_ch1,
  input  wire logic signed [mwf_pkg::NOISE_BITS-1:0] in_wow_noise,
  input  wire logic signed [mwf_pkg::NOISE_BITS-1:0] in_jitter_noise,
  input  wire mwf_pkg::q_stat_t        q_stat,
  output logic                         push,
  output logic [EntryWidth-1:0]        push_data
);
  import mwf_pkg::*;

  localparam int DW   = $clog2(BufferDepth) + 8;
  localparam int IW   = $clog2(SineTableSize + 1);
  localparam int RomN = SineTableSize + 1;
  localparam logic signed [31:0] DMax = 32'sd256 * 32'(BufferDepth - 2);

  typedef logic [22:0] rom_t [RomN];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] x, x2, t, s, v;
    for (int k = 0; k < RomN; k++) begin
      x  = (64'(k) * HALF_PI_Q30 + 64'(SineTableSize / 2)) / 64'(SineTableSize);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s + 64'd64) >> 7;
      if (v > MAX_Q23_U) begin
        v = MAX_Q23_U;
      end
      r[k] = v[22:0];
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  typedef enum logic [3:0] {
    F_IDLE, F_M1, F_M2, F_M3, F_M4, F_M5, F_M6, F_M7, F_M8, F_PUSH
  } fstate_t;

  fstate_t                 st_r;
  logic signed [23:0]      wow_r;
  logic [31:0]             phase_r;
  logic signed [41:0]      wprod_r;
  logic [31:0]             jamt_r;
  logic signed [23:0]      jn_r;
  logic signed [56:0]      jprod_r;
  logic signed [40:0]      pw_r;
  logic [IW-1:0]           saddr_r;
  logic [1:0]              quad_r;
  logic [22:0]             rom_q_r;
  logic signed [41:0]      ps_r;
  logic signed [24:0]      mod_r;
  logic signed [44:0]      dprod_r;
  logic [DW-1:0]           delay_r;
  logic [SampleBits-1:0]   s0_r, s1_r;
  logic [1:0]              proc_r;

  logic signed [24:0]      wdiff;
  logic signed [41:0]      wmul;
  logic [47:0]             jamt_full;
  logic signed [26:0]      wsum;
  logic signed [23:0]      wow_nxt;
  logic signed [56:0]      jmul;
  logic [42:0]             pos_prod;
  logic [IW-1:0]           idx;
  logic signed [24:0]      sine_c;
  logic signed [41:0]      smul;
  logic signed [42:0]      msum;
  logic signed [44:0]      dmul;
  logic signed [31:0]      dsum;
  logic [DW-1:0]           delay_nxt;
  logic [1:0]              nact;
  logic                    accept;

  assign in_ready = (st_r == F_IDLE) && !q_stat.full && !clearing;
  assign accept   = in_valid && in_ready;

  always_comb begin
    wdiff     = 25'(in_wow_noise) - 25'(wow_r);
    wmul      = $signed({1'b0, cfg.wow_coefficient}) * wdiff;
    jamt_full = 48'(cfg.flutter_increment) * 48'(cfg.jitter_gain);
    wsum      = 27'(wow_r) + 27'($signed(wprod_r[41:16]));
    if (wsum > MAX_Q23) begin
      wow_nxt = 24'(MAX_Q23);
    end else if (wsum < MIN_Q23) begin
      wow_nxt = 24'(MIN_Q23);
    end else begin
      wow_nxt = wsum[23:0];
    end
    jmul     = $signed({1'b0, jamt_r}) * jn_r;
    pos_prod = 43'(phase_r[29:0]) * 43'(SineTableSize);
    idx      = IW'(pos_prod[42:30]);
    sine_c   = quad_r[1] ? -$signed({2'b00, rom_q_r}) : $signed({2'b00, rom_q_r});
    smul     = sine_c * $signed(SINE_MIX);
    msum     = 43'(pw_r) + 43'(ps_r);
    dmul     = $signed({1'b0, cfg.depth}) * mod_r;
    dsum     = $signed({13'b0, cfg.base_delay}) + 32'($signed(dprod_r[44:23]));
    if (dsum < 32'sd0) begin
      delay_nxt = '0;
    end else if (dsum > DMax) begin
      delay_nxt = DW'(DMax);
    end else begin
      delay_nxt = DW'(dsum);
    end
    nact = (cfg.active_channels > 2'(Channels)) ? 2'(Channels) : cfg.active_channels;
  end

  // A bypass beat goes straight into the queue; an effect beat is pushed from
  // the registers once the delay is known.
  always_comb begin
    if (st_r == F_IDLE) begin
      push      = accept && !cfg.effect_on;
      push_data = {1'b1, 2'b00, {DW{1'b0}}, in_sample_ch0, in_sample_ch1};
    end else begin
      push      = (st_r == F_PUSH) && !q_stat.full;
      push_data = {1'b0, proc_r, delay_r, s0_r, s1_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= F_IDLE;
      wow_r   <= '0;
      phase_r <= '0;
    end else begin
      case (st_r)
        F_IDLE: begin
          if (accept && cfg.effect_on) begin
            st_r <= F_M1;
          end
        end
        F_M1: begin
          wow_r <= wow_nxt;
          st_r  <= F_M2;
        end
        F_M2: begin
          phase_r <= phase_r + cfg.flutter_increment + jprod_r[54:23];
          st_r    <= F_M3;
        end
        F_M3: st_r <= F_M4;
        F_M4: st_r <= F_M5;
        F_M5: st_r <= F_M6;
        F_M6: st_r <= F_M7;
        F_M7: st_r <= F_M8;
        F_M8: st_r <= F_PUSH;
        F_PUSH: begin
          if (!q_stat.full) begin
            st_r <= F_IDLE;
          end
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_r    <= in_sample_ch0;
      s1_r    <= in_sample_ch1;
      jn_r    <= in_jitter_noise;
      wprod_r <= wmul;
      jamt_r  <= jamt_full[47:16];
      proc_r  <= {nact > 2'd1, nact > 2'd0};
    end
    if (st_r == F_M1) begin
      jprod_r <= jmul;
    end
    if (st_r == F_M2) begin
      pw_r <= wow_r * $signed(WOW_MIX);
    end
    if (st_r == F_M3) begin
      quad_r  <= phase_r[31:30];
      saddr_r <= phase_r[30] ? IW'(SineTableSize) - idx : idx;
    end
    if (st_r == F_M4) begin
      rom_q_r <= SineRom[saddr_r];
    end
    if (st_r == F_M5) begin
      ps_r <= smul;
    end
    if (st_r == F_M6) begin
      mod_r <= msum[40:16];
    end
    if (st_r == F_M7) begin
      dprod_r <= dmul;
    end
    if (st_r == F_M8) begin
      delay_r <= delay_nxt;
    end
  end

endmodule

`default_nettype wire

### src/mwf_back.sv
// ----------------------------------------------------------------------------
// Delay back end
// Writes samples into the per-channel delay stores and interpolates the tap.
// ----------------------------------------------------------------------------
`default_nettype none

module mwf_back #(
  parameter int BufferDepth = 2048,
  parameter int Channels    = 2,
  parameter int SampleBits  = 24,
  parameter int EntryWidth  = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mwf_pkg::q_stat_t      q_stat,
  input  wire logic [EntryWidth-1:0] pop_data,
  output logic                       pop,
  output logic                       clearing,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [SampleBits-1:0]      out_ch0,
  output logic [SampleBits-1:0]      out_ch1
);
  import mwf_pkg::*;

  localparam int AW = $clog2(BufferDepth);
  localparam int DW = AW + 8;
  localparam int PW = SampleBits + 10;

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_ADDR, B_READ, B_MUL, B_OUT
  } bstate_t;

  bstate_t                st_r;
  logic [AW-1:0]          clr_cnt_r;
  logic [AW-1:0]          wpos_r;
  logic [EntryWidth-1:0]  ent_r;
  logic [AW-1:0]          i0_r, i1_r;
  logic [7:0]             frac_r;
  logic                   out_valid_r;
  logic [SampleBits-1:0]  out_r [2];

  logic                   e_bypass;
  logic [1:0]             e_proc;
  logic [DW-1:0]          e_delay;
  logic [SampleBits-1:0]  e_smp [2];
  logic signed [DW:0]     rd;
  logic [DW:0]            rdw;
  logic [AW-1:0]          i0;
  logic                   out_free;
  logic [SampleBits-1:0]  lane_res [2];

  assign {e_bypass, e_proc, e_delay, e_smp[0], e_smp[1]} = ent_r;

  assign pop      = (st_r == B_IDLE) && !q_stat.empty;
  assign clearing = (st_r == B_CLEAR);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    rd  = $signed({1'b0, wpos_r, 8'b0}) - $signed({1'b0, e_delay});
    rdw = rd[DW] ? (DW+1)'(rd) + (DW+1)'(BufferDepth * 256) : (DW+1)'(rd);
    i0  = rdw[DW-1:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_CLEAR;
      clr_cnt_r   <= '0;
      wpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (st_r == B_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        B_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW'(BufferDepth - 1)) begin
            st_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_stat.empty) begin
            st_r <= B_ADDR;
          end
        end
        B_ADDR: begin
          if (e_bypass) begin
            st_r <= B_OUT;
          end else begin
            wpos_r <= (wpos_r == AW'(BufferDepth - 1)) ? '0 : wpos_r + 1'b1;
            st_r   <= B_READ;
          end
        end
        B_READ: st_r <= B_MUL;
        B_MUL:  st_r <= B_OUT;
        B_OUT: begin
          if (out_free) begin
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= pop_data;
    end
    if (st_r == B_ADDR) begin
      i0_r   <= i0;
      i1_r   <= (i0 == AW'(BufferDepth - 1)) ? '0 : i0 + 1'b1;
      frac_r <= rdw[7:0];
    end
    if (st_r == B_OUT && out_free) begin
      out_r[0] <= lane_res[0];
      out_r[1] <= lane_res[1];
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_lane
    if (g < Channels) begin : g_mem
      logic [SampleBits-1:0]    store [BufferDepth];
      logic signed [SampleBits-1:0] q0_r, q1_r;
      logic signed [PW-1:0]     prod_r;
      logic signed [SampleBits:0] diff;
      logic signed [PW-1:0]     sum;
      logic                     we;
      logic [AW-1:0]            wa;
      logic [SampleBits-1:0]    wd;

      always_comb begin
        we   = clearing || (st_r == B_ADDR && !e_bypass && e_proc[g]);
        wa   = clearing ? clr_cnt_r : wpos_r;
        wd   = clearing ? '0 : e_smp[g];
        diff = (SampleBits+1)'(q1_r) - (SampleBits+1)'(q0_r);
        sum  = PW'(q0_r) + (prod_r >>> 8);
        lane_res[g] = (e_bypass || !e_proc[g]) ? e_smp[g] : sum[SampleBits-1:0];
      end

      always_ff @(posedge clk) begin
        if (we) begin
          store[wa] <= wd;
        end
        if (st_r == B_READ) begin
          q0_r <= store[i0_r];
          q1_r <= store[i1_r];
        end
        if (st_r == B_MUL) begin
          prod_r <= $signed({1'b0, frac_r}) * diff;
        end
      end
    end else begin : g_pass
      assign lane_res[g] = e_smp[g];
    end
  end

  assign out_valid = out_valid_r;
  assign out_ch0   = out_r[0];
  assign out_ch1   = out_r[1];

  ap_no_pop_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_CLEAR) |-> !pop)
    else $error("queue popped during the clearing pass");

  ap_wpos_range : assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r <= AW'(BufferDepth - 1))
    else $error("write position out of range");

  ap_hold_result : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_OUT && out_valid_r && !out_ready) |=> (st_r == B_OUT))
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

### src/modulated_delay_wow_flutter.sv
// ----------------------------------------------------------------------------
// Wow and flutter modulated delay line
// Stereo delay whose length follows smoothed wow noise and a jittered sine.
// ----------------------------------------------------------------------------
//  Port group   Direction  Handshake              Content
//  in_*         in         in_valid / in_ready    two samples, wow and jitter noise
//  out_*        out        out_valid / out_ready  two delayed samples
//  cfg_*        in/out     psel/penable, pready   seven control registers
//
// A frame with the effect on passes the modulation front end states M1 to M8
// and PUSH (the wow, flutter, sine and delay multiplies run one after the other);
// a bypass frame goes straight into the queue. The delay back end runs an
// effect frame through ADDR, READ, MUL and OUT, for the store read and the
// interpolation multiply, and a bypass frame through ADDR and OUT.
// After reset a clearing pass zeroes every entry of the delay stores;
// in_ready stays low during it. Either side can stall without losing a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module modulated_delay_wow_flutter #(
  parameter int BufferDepth   = mwf_pkg::BUFFER_DEPTH_DEF,
  parameter int Channels      = mwf_pkg::CHANNELS_DEF,
  parameter int SineTableSize = mwf_pkg::SINE_TABLE_SIZE_DEF,
  parameter int SampleBits    = mwf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [SampleBits-1:0]        in_sample_ch0,
  input  wire logic [SampleBits-1:0]        in_sample_ch1,
  input  wire logic signed [mwf_pkg::NOISE_BITS-1:0] in_wow_noise,
  input  wire logic signed [mwf_pkg::NOISE_BITS-1:0] in_jitter_noise,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [SampleBits-1:0]             out_ch0,
  output logic [SampleBits-1:0]             out_ch1,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [mwf_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [31:0]                  cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import mwf_pkg::*;

  localparam int DW         = $clog2(BufferDepth) + 8;
  localparam int EntryWidth = 3 + DW + 2 * SampleBits;

  cfg_t                  cfg_r;
  logic                  wr_en;
  logic [2:0]            reg_idx;
  q_stat_t               q_stat;
  logic                  push, pop, clearing;
  logic [EntryWidth-1:0] push_data, pop_data;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.effect_on         <= 1'b0;
      cfg_r.active_channels   <= 2'd2;
      cfg_r.base_delay        <= '0;
      cfg_r.depth             <= '0;
      cfg_r.wow_coefficient   <= '0;
      cfg_r.flutter_increment <= '0;
      cfg_r.jitter_gain       <= 16'd5243;
    end else if (wr_en) begin
      case (reg_idx)
        REG_EFFECT_ON:   cfg_r.effect_on         <= cfg_pwdata[0];
        REG_ACTIVE_CH:   cfg_r.active_channels   <= cfg_pwdata[1:0];
        REG_BASE_DELAY:  cfg_r.base_delay        <= cfg_pwdata[18:0];
        REG_DEPTH:       cfg_r.depth             <= cfg_pwdata[18:0];
        REG_WOW_COEF:    cfg_r.wow_coefficient   <= cfg_pwdata[15:0];
        REG_FLUTTER_INC: cfg_r.flutter_increment <= cfg_pwdata;
        REG_JITTER_GAIN: cfg_r.jitter_gain       <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EFFECT_ON:   cfg_prdata = 32'(cfg_r.effect_on);
      REG_ACTIVE_CH:   cfg_prdata = 32'(cfg_r.active_channels);
      REG_BASE_DELAY:  cfg_prdata = 32'(cfg_r.base_delay);
      REG_DEPTH:       cfg_prdata = 32'(cfg_r.depth);
      REG_WOW_COEF:    cfg_prdata = 32'(cfg_r.wow_coefficient);
      REG_FLUTTER_INC: cfg_prdata = cfg_r.flutter_increment;
      REG_JITTER_GAIN: cfg_prdata = 32'(cfg_r.jitter_gain);
      default:         cfg_prdata = '0;
    endcase
  end

  mwf_front #(
    .BufferDepth  (BufferDepth),
    .Channels     (Channels),
    .SineTableSize(SineTableSize),
    .SampleBits   (SampleBits),
    .EntryWidth   (EntryWidth)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .clearing       (clearing),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_ch0  (in_sample_ch0),
    .in_sample_ch1  (in_sample_ch1),
    .in_wow_noise   (in_wow_noise),
    .in_jitter_noise(in_jitter_noise),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  mwf_queue #(
    .Width(EntryWidth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .stat     (q_stat)
  );

  mwf_back #(
    .BufferDepth(BufferDepth),
    .Channels   (Channels),
    .SampleBits (SampleBits),
    .EntryWidth (EntryWidth)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_ch0  (out_ch0),
    .out_ch1  (out_ch1)
  );

endmodule

`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// Modulated delay line testbench
// Drives random and directed stereo frames with noise into the wow and
// flutter delay line under several register settings and idling patterns,
// and checks every output beat against a cycle-free predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import mwf_pkg::*;

  localparam int DEPTH_N = 2048;
  localparam int TBL_N   = 1024;

  typedef struct packed {
    logic [23:0] ch0;
    logic [23:0] ch1;
    logic [23:0] wow_n;
    logic [23:0] jit_n;
  } frame_t;

  typedef struct packed {
    logic [23:0] ch0;
    logic [23:0] ch1;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_taken = 1'b0;
  logic [23:0] in_sample_ch0 = '0;
  logic [23:0] in_sample_ch1 = '0;
  logic signed [23:0] in_wow_noise = '0;
  logic signed [23:0] in_jitter_noise = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [23:0] out_ch0;
  logic [23:0] out_ch1;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_BITS-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  modulated_delay_wow_flutter u_top (.*);

  // Predictor state and registers.
  cfg_t        regs;
  logic signed [23:0] store_m [2][DEPTH_N];
  int          wpos;
  longint      wow_lvl;
  logic [31:0] phase;

  frame_t pending_frames[$];
  pair_t  expected_pairs[$];
  int     fail_count = 0;
  int     send_idle = 0;   // percent
  int     recv_stall = 0;  // percent

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint fshift(longint x, int s);
    return x >>> s;  // arithmetic shift is floor division
  endfunction

  function automatic longint sine_entry(longint k);
    longint unsigned x, x2, t, s, v;
    longint unsigned divs[6];
    divs = '{156, 110, 72, 42, 20, 6};
    x = (k * 64'd1686629713 + TBL_N / 2) / TBL_N;
    x2 = (x * x) >> 30;
    t = 64'd1073741824;
    for (int i = 0; i < 6; i++) t = 64'd1073741824 - ((x2 * t) >> 30) / divs[i];
    s = (x * t) >> 30;
    v = (s + 64) >> 7;
    if (v > 8388607) v = 8388607;
    return longint'(v);
  endfunction

  function automatic longint phase_to_sine(logic [31:0] ph);
    longint unsigned idx;
    longint v;
    idx = ({34'd0, ph[29:0]} * TBL_N) >> 30;
    if (ph[30]) idx = TBL_N - idx;
    v = sine_entry(longint'(idx));
    return ph[31] ? -v : v;
  endfunction

  function automatic pair_t predict_frame(frame_t f);
    pair_t r;
    longint wn, jn, w, jamt, jit, sn, md, dly, rd, s0, s1, fr;
    int nact, i0, i1;
    logic [23:0] smp;
    r.ch0 = f.ch0;
    r.ch1 = f.ch1;
    if (!regs.effect_on) return r;
    wn = longint'(signed'(f.wow_n));
    jn = longint'(signed'(f.jit_n));
    w = wow_lvl + fshift(longint'(regs.wow_coefficient) * (wn - wow_lvl), 16);
    if (w > 8388607) w = 8388607;
    if (w < -8388608) w = -8388608;
    wow_lvl = w;
    jamt = (longint'(regs.flutter_increment) * longint'(regs.jitter_gain)) >>> 16;
    jit = fshift(jamt * jn, 23);
    phase = phase + regs.flutter_increment + 32'(jit);
    sn = phase_to_sine(phase);
    md = fshift(wow_lvl * 39322 + sn * 26214, 16);
    dly = longint'(regs.base_delay) + fshift(longint'(regs.depth) * md, 23);
    if (dly < 0) dly = 0;
    if (dly > (DEPTH_N - 2) * 256) dly = (DEPTH_N - 2) * 256;
    nact = (regs.active_channels > 2) ? 2 : regs.active_channels;
    for (int ch = 0; ch < nact; ch++) begin
      smp = (ch == 0) ? f.ch0 : f.ch1;
      store_m[ch][wpos] = smp;
      rd = longint'(wpos) * 256 - dly;
      if (rd < 0) rd += DEPTH_N * 256;
      i0 = int'(rd >>> 8);
      if (i0 >= DEPTH_N) i0 = DEPTH_N - 1;
      i1 = (i0 + 1 >= DEPTH_N) ? 0 : i0 + 1;
      fr = rd & 255;
      s0 = longint'(store_m[ch][i0]);
      s1 = longint'(store_m[ch][i1]);
      smp = 24'(s0 + fshift(fr * (s1 - s0), 8));
      if (ch == 0) r.ch0 = smp; else r.ch1 = smp;
    end
    wpos = (wpos + 1 >= DEPTH_N) ? 0 : wpos + 1;
    return r;
  endfunction

  // Driver: presents queued frames, predicts each one as its beat is taken.
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (in_valid && in_ready) begin
      expected_pairs.push_back(predict_frame(pending_frames.pop_front()));
    end
  end

  // The driver pops on acceptance, so a new beat is presented only once the
  // previous one has been taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_sample_ch0 <= pending_frames[0].ch0;
        in_sample_ch1 <= pending_frames[0].ch1;
        in_wow_noise <= pending_frames[0].wow_n;
        in_jitter_noise <= pending_frames[0].jit_n;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Monitor: compare each output beat with the oldest prediction.
  always @(posedge clk) begin
    pair_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pairs.size() == 0) begin
        $error("output beat with no prediction waiting");
        fail_count++;
      end else begin
        e = expected_pairs.pop_front();
        if (out_ch0 !== e.ch0) begin
          $error("out_ch0 expected %h actual %h", e.ch0, out_ch0);
          fail_count++;
        end
        if (out_ch1 !== e.ch1) begin
          $error("out_ch1 expected %h actual %h", e.ch1, out_ch1);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_BITS'({idx, 2'b00});
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_EFFECT_ON:   regs.effect_on = val[0];
      REG_ACTIVE_CH:   regs.active_channels = val[1:0];
      REG_BASE_DELAY:  regs.base_delay = val[18:0];
      REG_DEPTH:       regs.depth = val[18:0];
      REG_WOW_COEF:    regs.wow_coefficient = val[15:0];
      REG_FLUTTER_INC: regs.flutter_increment = val;
      REG_JITTER_GAIN: regs.jitter_gain = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_frames.size() > 0 || expected_pairs.size() > 0 || in_valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic add_frame(logic [23:0] a, logic [23:0] b, logic [23:0] w, logic [23:0] j);
    frame_t f;
    f.ch0 = a; f.ch1 = b; f.wow_n = w; f.jit_n = j;
    pending_frames.push_back(f);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      add_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
  endtask

  task automatic random_settings();
    write_reg(REG_ACTIVE_CH, $urandom_range(3));
    write_reg(REG_BASE_DELAY, ($urandom_range(3) == 0) ? $urandom_range(524287)
                                                         : $urandom_range(2047 * 256));
    write_reg(REG_DEPTH, ($urandom_range(3) == 0) ? $urandom_range(524287)
                                                    : $urandom_range(64 * 256));
    write_reg(REG_WOW_COEF, $urandom_range(65535));
    write_reg(REG_FLUTTER_INC, $urandom);
    write_reg(REG_JITTER_GAIN, $urandom_range(65535));
    write_reg(REG_EFFECT_ON, 32'($urandom_range(7) != 0));
  endtask

  initial begin
    regs = '{effect_on: 1'b0, active_channels: 2'd2, base_delay: '0, depth: '0,
             wow_coefficient: '0, flutter_increment: '0, jitter_gain: 16'd5243};
    foreach (store_m[c, k]) store_m[c][k] = '0;
    wpos = 0;
    wow_lvl = 0;
    phase = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Bypass with the effect off, extremes of every field.
    add_frame(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
    add_frame(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    drain();

    // Zero delay returns the sample just written.
    write_reg(REG_EFFECT_ON, 32'd1);
    add_frame(24'h123456, 24'hABCDEF, 24'h0, 24'h0);
    add_frame(24'h7FFFFF, 24'h800000, 24'h0, 24'h0);
    drain();

    // Saturated delay, strong wow, extreme flutter, then zero, one and three active channels.
    write_reg(REG_BASE_DELAY, 32'h0007FF00);
    write_reg(REG_DEPTH, 32'h0007FF00);
    write_reg(REG_WOW_COEF, 32'h0000FFFF);
    write_reg(REG_FLUTTER_INC, 32'h80000000);
    write_reg(REG_JITTER_GAIN, 32'h0000FFFF);
    for (int i = 0; i < 6; i++)
      add_frame(rand_sample(), rand_sample(), (i & 1) ? 24'h800000 : 24'h7FFFFF,
                (i & 2) ? 24'h800000 : 24'h7FFFFF);
    drain();
    write_reg(REG_ACTIVE_CH, 32'd0);
    random_phase(4);
    drain();
    write_reg(REG_ACTIVE_CH, 32'd1);
    write_reg(REG_BASE_DELAY, 32'd256);
    write_reg(REG_DEPTH, 32'd0);
    random_phase(4);
    drain();
    write_reg(REG_ACTIVE_CH, 32'd3);
    write_reg(REG_BASE_DELAY, 32'd384);
    random_phase(5);
    drain();

    // Random phases under each idling pattern.
    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 87; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 87; end
        default: begin send_idle = 27; recv_stall = 27; end
      endcase
      random_settings();
      random_phase(75);
      // Let every result come back before sending more.
      while (pending_frames.size() > 0 || in_valid) @(posedge clk);
      while (expected_pairs.size() > 0) @(posedge clk);
      random_phase(75);
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
